>>> hdl/qoienc_pkg.sv
package qoienc_pkg;

  // Input item codes
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Configuration register indexes
  localparam logic [3:0] CFG_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_HEIGHT = 4'd1;
  localparam logic [3:0] CFG_CHANS  = 4'd2;
  localparam logic [3:0] CFG_CSPACE = 4'd3;

  // Stream op codes
  localparam logic [7:0] OPC_INDEX = 8'h00;
  localparam logic [7:0] OPC_DIFF  = 8'h40;
  localparam logic [7:0] OPC_LUMA  = 8'h80;
  localparam logic [7:0] OPC_RUN   = 8'hc0;
  localparam logic [7:0] OPC_RGB   = 8'hfe;
  localparam logic [7:0] OPC_RGBA  = 8'hff;

  localparam logic [5:0] RUN_LIMIT  = 6'd62;
  localparam int         SLOT_COUNT = 64;
  localparam int         SLOT_AW    = $clog2(SLOT_COUNT);

  // Header magic "qoif"
  localparam logic [31:0] MAGIC = 32'h716f6966;
  localparam logic [3:0]  HDR_LEN = 4'd14;
  localparam logic [3:0]  END_LEN = 4'd8;

  // Command queue between classifier and serializer
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CMD_PIX,
    CMD_HDR,
    CMD_END
  } cmd_kind_t;

  // PIX: cnt bytes from bytes[]; END: cnt is 1 when bytes[0] holds a run flush
  typedef struct packed {
    cmd_kind_t       kind;
    logic [2:0]      cnt;
    logic [5:0][7:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic [2:0]  chans;
    logic [7:0]  cspace;
  } cfg_t;

  // Hash slot: (3r + 5g + 7b + 11a) mod 64
  function automatic logic [SLOT_AW-1:0] hash_slot(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b, input logic [7:0] a);
    logic [SLOT_AW-1:0] sr, sg, sb, sa;
    sr = SLOT_AW'(r) * SLOT_AW'(3);
    sg = SLOT_AW'(g) * SLOT_AW'(5);
    sb = SLOT_AW'(b) * SLOT_AW'(7);
    sa = SLOT_AW'(a) * SLOT_AW'(11);
    return SLOT_AW'(sr + sg + sb + sa);
  endfunction

endpackage

>>> hdl/qoi_image_encoder.sv
// QOI image encoder: start, pixel and end items in, encoded stream bytes out.
// Items pass the lookup stage, then the command queue, then the output register.
// Throughput: one item per cycle while each emits at most one byte; the byte
// serializer sends one byte per cycle unless out_stall is high, so multi-byte
// ops stall the input once the 4-entry queue fills. Header 14 bytes, end 8 or 9.
// Sync reset (rst_n low) clears queue, run, slot valids; prev pixel 0x000000ff.
module qoi_image_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  qoienc_pkg::cfg_t cfg_r;
  qoienc_pkg::cmd_t push_cmd;
  qoienc_pkg::cmd_t q_cmd;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 32'd0;
      cfg_r.height <= 32'd0;
      cfg_r.chans  <= 3'd4;
      cfg_r.cspace <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qoienc_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_data;
        qoienc_pkg::CFG_HEIGHT: cfg_r.height <= cfg_data;
        qoienc_pkg::CFG_CHANS:  cfg_r.chans  <= cfg_data[2:0];
        qoienc_pkg::CFG_CSPACE: cfg_r.cspace <= cfg_data[7:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  qoienc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_alpha (in_alpha),
    .cfg      (cfg_r),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  qoienc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  qoienc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

>>> hdl/qoienc_front.sv
module qoienc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_alpha,
  input  qoienc_pkg::cfg_t   cfg,
  output logic               push,
  output qoienc_pkg::cmd_t   push_cmd,
  input  logic               q_full
);

  localparam int AW = qoienc_pkg::SLOT_AW;

  // Colour index memory and per-slot valid bits
  logic [31:0]                       mem [qoienc_pkg::SLOT_COUNT];
  logic [qoienc_pkg::SLOT_COUNT-1:0] slot_valid_r, slot_valid_nxt;

  // Lookup stage
  logic          s1_valid_r;
  logic [1:0]    s1_op_r;
  logic [31:0]   s1_px_r;
  logic [AW-1:0] s1_slot_r;
  logic [31:0]   s1_rd_r;

  // Encoder state
  logic [31:0] prev_r, prev_nxt;
  logic [5:0]  run_r, run_nxt;

  logic          acc;
  logic [7:0]    alpha_eff;
  logic [AW-1:0] rd_slot;
  logic          s1_done;
  logic          need_push;
  logic          mem_we;

  logic          same, hit, flush;
  logic [5:0]    run_inc;
  logic [7:0]    run_byte;
  logic [7:0]    dr, dg, db, dgr, dgb;
  logic [7:0]    dr2, dg2, db2, lg, lr, lb;
  logic          is_diff, is_luma;
  logic [4:0][7:0] body;
  logic [2:0]    nbody;

  // Accept when the lookup stage is empty or retires this cycle
  assign s1_done  = s1_valid_r && (!need_push || !q_full);
  assign in_stall = s1_valid_r && !s1_done;
  assign acc      = in_valid && !in_stall;

  assign alpha_eff = (cfg.chans == 3'd3) ? 8'hff : in_alpha;
  assign rd_slot   = qoienc_pkg::hash_slot(in_red, in_green, in_blue, alpha_eff);

  // Channel differences against the previous pixel
  assign dr  = s1_px_r[31:24] - prev_r[31:24];
  assign dg  = s1_px_r[23:16] - prev_r[23:16];
  assign db  = s1_px_r[15:8]  - prev_r[15:8];
  assign dgr = dr - dg;
  assign dgb = db - dg;
  assign dr2 = dr + 8'd2;
  assign dg2 = dg + 8'd2;
  assign db2 = db + 8'd2;
  assign lg  = dg + 8'd32;
  assign lr  = dgr + 8'd8;
  assign lb  = dgb + 8'd8;
  assign is_diff = (dr2 < 8'd4) && (dg2 < 8'd4) && (db2 < 8'd4);
  assign is_luma = (lg < 8'd64) && (lr < 8'd16) && (lb < 8'd16);

  assign same     = (s1_px_r == prev_r);
  // Unwritten slots read as zero
  assign hit      = ((slot_valid_r[s1_slot_r] ? s1_rd_r : 32'h0) == s1_px_r);
  assign flush    = (run_r != 6'd0);
  assign run_inc  = run_r + 6'd1;
  assign run_byte = qoienc_pkg::OPC_RUN | {2'b00, 6'(run_r - 6'd1)};

  // Pick the op bytes for a pixel that differs from the previous one
  always_comb begin
    body  = '0;
    nbody = 3'd1;
    if (hit) begin
      body[0] = qoienc_pkg::OPC_INDEX | {2'b00, s1_slot_r};
    end else if (s1_px_r[7:0] != prev_r[7:0]) begin
      body[0] = qoienc_pkg::OPC_RGBA;
      body[1] = s1_px_r[31:24];
      body[2] = s1_px_r[23:16];
      body[3] = s1_px_r[15:8];
      body[4] = s1_px_r[7:0];
      nbody   = 3'd5;
    end else if (is_diff) begin
      body[0] = qoienc_pkg::OPC_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
    end else if (is_luma) begin
      body[0] = qoienc_pkg::OPC_LUMA | {2'b00, lg[5:0]};
      body[1] = {lr[3:0], lb[3:0]};
      nbody   = 3'd2;
    end else begin
      body[0] = qoienc_pkg::OPC_RGB;
      body[1] = s1_px_r[31:24];
      body[2] = s1_px_r[23:16];
      body[3] = s1_px_r[15:8];
      nbody   = 3'd4;
    end
  end

  // Classify the item in the lookup stage and work out the next state
  always_comb begin
    need_push      = 1'b0;
    push_cmd       = '0;
    push_cmd.kind  = qoienc_pkg::CMD_PIX;
    prev_nxt       = prev_r;
    run_nxt        = run_r;
    slot_valid_nxt = slot_valid_r;
    mem_we         = 1'b0;
    unique case (s1_op_r)
      qoienc_pkg::OP_PIXEL: begin
        prev_nxt = s1_px_r;
        if (same) begin
          if (run_inc == qoienc_pkg::RUN_LIMIT) begin
            need_push         = 1'b1;
            push_cmd.cnt      = 3'd1;
            push_cmd.bytes[0] = qoienc_pkg::OPC_RUN | {2'b00, 6'(run_inc - 6'd1)};
            run_nxt           = 6'd0;
          end else begin
            run_nxt = run_inc;
          end
        end else begin
          need_push = 1'b1;
          run_nxt   = 6'd0;
          if (flush) begin
            push_cmd.bytes = {body, run_byte};
            push_cmd.cnt   = nbody + 3'd1;
          end else begin
            push_cmd.bytes = {8'h00, body};
            push_cmd.cnt   = nbody;
          end
          if (!hit) begin
            mem_we                    = 1'b1;
            slot_valid_nxt[s1_slot_r] = 1'b1;
          end
        end
      end
      qoienc_pkg::OP_START: begin
        need_push      = 1'b1;
        push_cmd.kind  = qoienc_pkg::CMD_HDR;
        prev_nxt       = 32'h000000ff;
        run_nxt        = 6'd0;
        slot_valid_nxt = '0;
      end
      qoienc_pkg::OP_END: begin
        need_push         = 1'b1;
        push_cmd.kind     = qoienc_pkg::CMD_END;
        push_cmd.cnt      = flush ? 3'd1 : 3'd0;
        push_cmd.bytes[0] = run_byte;
        run_nxt           = 6'd0;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign push = s1_valid_r && need_push && !q_full;

  // Hold control state; advance it when the staged item retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prev_r       <= 32'h000000ff;
      run_r        <= 6'd0;
      slot_valid_r <= '0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_done) begin
        prev_r       <= prev_nxt;
        run_r        <= run_nxt;
        slot_valid_r <= slot_valid_nxt;
      end
    end
  end

  // Capture the item and read its slot, bypassing a same-cycle write
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op_r   <= in_op;
      s1_px_r   <= {in_red, in_green, in_blue, alpha_eff};
      s1_slot_r <= rd_slot;
      if (s1_done && mem_we && (s1_slot_r == rd_slot)) begin
        s1_rd_r <= s1_px_r;
      end else begin
        s1_rd_r <= mem[rd_slot];
      end
    end
    if (s1_done && mem_we) begin
      mem[s1_slot_r] <= s1_px_r;
    end
  end

  // A run never rests at the flush limit
  a_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < qoienc_pkg::RUN_LIMIT)
    else $error("run length reached flush limit without flushing");

endmodule

>>> hdl/qoienc_queue.sv
module qoienc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qoienc_pkg::cmd_t push_cmd,
  output logic             q_full,
  output logic             q_valid,
  output qoienc_pkg::cmd_t q_cmd,
  input  logic             q_pop
);

  localparam int AW = qoienc_pkg::Q_AW;

  qoienc_pkg::cmd_t mem_r [qoienc_pkg::Q_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      cnt_r;

  assign q_full  = (cnt_r == (AW+1)'(qoienc_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

endmodule

>>> hdl/qoienc_back.sv
module qoienc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  qoienc_pkg::cmd_t q_cmd,
  output logic             q_pop,
  input  qoienc_pkg::cfg_t cfg,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [3:0] idx_r;

  logic [3:0] total;
  logic       last;
  logic       load;
  logic [7:0] sel_byte;

  assign load  = q_valid && (!out_valid_r || !out_stall);
  assign last  = (idx_r == total - 4'd1);
  assign q_pop = load && last;

  // Byte count of the head command
  always_comb begin
    unique case (q_cmd.kind)
      qoienc_pkg::CMD_PIX: total = {1'b0, q_cmd.cnt};
      qoienc_pkg::CMD_HDR: total = qoienc_pkg::HDR_LEN;
      qoienc_pkg::CMD_END: total = qoienc_pkg::END_LEN + {3'b000, q_cmd.cnt[0]};
      default:             total = 4'd1;
    endcase
  end

  // Select the byte at the current position of the head command
  always_comb begin
    sel_byte = 8'h00;
    unique case (q_cmd.kind)
      qoienc_pkg::CMD_PIX: begin
        sel_byte = q_cmd.bytes[idx_r[2:0]];
      end
      qoienc_pkg::CMD_HDR: begin
        unique case (idx_r)
          4'd0:    sel_byte = qoienc_pkg::MAGIC[31:24];
          4'd1:    sel_byte = qoienc_pkg::MAGIC[23:16];
          4'd2:    sel_byte = qoienc_pkg::MAGIC[15:8];
          4'd3:    sel_byte = qoienc_pkg::MAGIC[7:0];
          4'd4:    sel_byte = cfg.width[31:24];
          4'd5:    sel_byte = cfg.width[23:16];
          4'd6:    sel_byte = cfg.width[15:8];
          4'd7:    sel_byte = cfg.width[7:0];
          4'd8:    sel_byte = cfg.height[31:24];
          4'd9:    sel_byte = cfg.height[23:16];
          4'd10:   sel_byte = cfg.height[15:8];
          4'd11:   sel_byte = cfg.height[7:0];
          4'd12:   sel_byte = {5'b00000, cfg.chans};
          default: sel_byte = cfg.cspace;
        endcase
      end
      qoienc_pkg::CMD_END: begin
        if (q_cmd.cnt[0] && (idx_r == 4'd0)) begin
          sel_byte = q_cmd.bytes[0];
        end else if (last) begin
          sel_byte = 8'h01;
        end else begin
          sel_byte = 8'h00;
        end
      end
      default: sel_byte = 8'h00;
    endcase
  end

  // Load the output register and step through the head command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 4'd0 : idx_r + 4'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_byte;
      out_last_r <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && out_last_r))
    else $error("command retired without a final byte");

  a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (idx_r == 4'd0))
    else $error("byte position left mid-command with queue empty");

endmodule
